FILE: rtl/assert_macros.svh
// Assertion macros shared by the clipping run detector RTL.
// No dependencies; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed: property does not hold");
// Condition must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

FILE: rtl/crd_pkg.sv
// Shared types and constants for the clipping run detector.
// No dependencies; imported by every module of the block.
package crd_pkg;

    // Default geometry
    localparam int CRD_CHANNELS   = 8;
    localparam int CRD_FRAME_BITS = 40;

    // Event bundles buffered between tracker update and output
    localparam int EVQ_DEPTH = 2;

    // Item opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Event kinds
    localparam logic [1:0] KIND_DIGITAL = 2'd0;
    localparam logic [1:0] KIND_OVER    = 2'd1;
    localparam logic [1:0] KIND_NEAR    = 2'd2;

    // Configuration register indexes
    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] REG_HARD_TH   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_NEAR_TH   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_MIN_HARD  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_MIN_NEAR  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_MERGE_GAP = 3'd4;
    localparam logic [CFG_AW-1:0] REG_FLOAT_SRC = 3'd5;

    // Configuration reset values
    localparam logic [31:0] RST_HARD_TH  = 32'd8388607;
    localparam logic [31:0] RST_NEAR_TH  = 32'd7476679;
    localparam logic [31:0] RST_MIN_RUN  = 32'd3;

    // Classified item handed from front to trackers
    typedef struct packed {
        logic        op;
        logic [2:0]  ch;
        logic [31:0] mag;
        logic        meets_hard;
        logic        meets_near;
    } t_cls;

    // One reported run
    typedef struct packed {
        logic [1:0]  kind;
        logic [39:0] run_start;
        logic [39:0] run_end;
        logic [31:0] run_peak;
        logic [31:0] run_count;
    } t_evt;

    // All events caused by one item, in output order (slot 0 first)
    typedef struct packed {
        logic [2:0]       ch;
        logic [3:0]       vld;
        t_evt [3:0]       ev;
    } t_bundle;

endpackage

FILE: rtl/crd_front.sv
// Front stage: accepts items, takes the magnitude, compares it with both
// thresholds and stamps the channel frame. Depends on crd_pkg.
module crd_front import crd_pkg::*; #(
    parameter int CHANNELS   = CRD_CHANNELS,
    parameter int FRAME_BITS = CRD_FRAME_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_op,
    input  logic [2:0]            i_ch,
    input  logic [31:0]           i_sample,
    input  logic [31:0]           i_hard_th,
    input  logic [31:0]           i_near_th,
    input  logic                  i_adv,
    output logic                  o_valid,
    output t_cls                  o_cls,
    output logic [FRAME_BITS-1:0] o_frame
);

    localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                  r_valid;
    t_cls                  r_cls;
    logic [FRAME_BITS-1:0] r_fstamp;
    logic [FRAME_BITS-1:0] r_frame [CHANNELS];

    logic           accept;
    logic           ch_ok;
    logic [CHW-1:0] ci;
    logic [31:0]    mag;

    assign o_ready = !r_valid || i_adv;
    assign accept  = i_valid && o_ready;
    assign ch_ok   = ({29'd0, i_ch} < 32'(CHANNELS));
    assign ci      = CHW'(i_ch);
    // Most negative sample folds to 2^31
    assign mag     = i_sample[31] ? (32'd0 - i_sample) : i_sample;

    // Hold the classified item until the trackers take it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= ch_ok;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cls.op         <= i_op;
            r_cls.ch         <= i_ch;
            r_cls.mag        <= mag;
            r_cls.meets_hard <= (mag >= i_hard_th);
            r_cls.meets_near <= (mag >= i_near_th);
            r_fstamp         <= r_frame[ci];
        end
    end

    // Advance the channel frame on samples, saturating at all ones
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_frame[i] <= '0;
            end
        end else if (accept && ch_ok && (i_op == OP_SAMPLE)) begin
            if (r_frame[ci] != {FRAME_BITS{1'b1}}) begin
                r_frame[ci] <= r_frame[ci] + FRAME_BITS'(1);
            end
        end
    end

    assign o_valid = r_valid;
    assign o_cls   = r_cls;
    assign o_frame = r_fstamp;

endmodule

FILE: rtl/crd_trk_bank.sv
// Run trackers of one kind for all channels: open run, held run, merging
// and the events they release. Depends on crd_pkg.
module crd_trk_bank import crd_pkg::*; #(
    parameter int CHANNELS   = CRD_CHANNELS,
    parameter int FRAME_BITS = CRD_FRAME_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_op,
    input  logic [2:0]            i_ch,
    input  logic [31:0]           i_mag,
    input  logic                  i_meets,
    input  logic [FRAME_BITS-1:0] i_frame,
    input  logic [1:0]            i_kind,
    input  logic [31:0]           i_merge_gap,
    input  logic [31:0]           i_min_run,
    output logic                  o_ev0_vld,
    output t_evt                  o_ev0,
    output logic                  o_ev1_vld,
    output t_evt                  o_ev1
);

    localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW  = (FRAME_BITS > 32) ? FRAME_BITS : 32;

    logic                  r_open   [CHANNELS];
    logic [FRAME_BITS-1:0] r_ostart [CHANNELS];
    logic [31:0]           r_opeak  [CHANNELS];
    logic [31:0]           r_ocount [CHANNELS];
    logic                  r_hvalid [CHANNELS];
    logic [FRAME_BITS-1:0] r_hstart [CHANNELS];
    logic [FRAME_BITS-1:0] r_hend   [CHANNELS];
    logic [31:0]           r_hpeak  [CHANNELS];
    logic [31:0]           r_hcount [CHANNELS];

    logic                  n_open;
    logic [FRAME_BITS-1:0] n_ostart;
    logic [31:0]           n_opeak;
    logic [31:0]           n_ocount;
    logic                  n_hvalid;
    logic [FRAME_BITS-1:0] n_hstart;
    logic [FRAME_BITS-1:0] n_hend;
    logic [31:0]           n_hpeak;
    logic [31:0]           n_hcount;

    logic [CHW-1:0]        ci;
    logic                  open, hvalid;
    logic [FRAME_BITS-1:0] ostart, hstart, hend;
    logic [31:0]           opeak, ocount, hpeak, hcount;
    logic [FRAME_BITS-1:0] gap, span;
    logic [31:0]           span_sat;
    logic                  do_merge, closing;

    assign ci     = CHW'(i_ch);
    assign open   = r_open[ci];
    assign hvalid = r_hvalid[ci];
    assign ostart = r_ostart[ci];
    assign opeak  = r_opeak[ci];
    assign ocount = r_ocount[ci];
    assign hstart = r_hstart[ci];
    assign hend   = r_hend[ci];
    assign hpeak  = r_hpeak[ci];
    assign hcount = r_hcount[ci];

    // Gap between held end and open start, floored at zero
    assign gap      = (ostart >= hend) ? (ostart - hend) : '0;
    assign do_merge = hvalid && (CW'(gap) <= CW'(i_merge_gap));
    // Merged span runs from held start to the closing frame
    assign span     = (i_frame >= hstart) ? (i_frame - hstart) : '0;
    assign span_sat = (CW'(span) > CW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(span);
    assign closing  = open && ((i_op == OP_FINISH) || !i_meets);

    // Next tracker state and released events
    always_comb begin
        n_open    = open;
        n_ostart  = ostart;
        n_opeak   = opeak;
        n_ocount  = ocount;
        n_hvalid  = hvalid;
        n_hstart  = hstart;
        n_hend    = hend;
        n_hpeak   = hpeak;
        n_hcount  = hcount;
        o_ev0_vld = 1'b0;
        o_ev1_vld = 1'b0;

        if (closing) begin
            n_open   = 1'b0;
            n_ocount = '0;
            n_hvalid = 1'b1;
            n_hend   = i_frame;
            if (do_merge) begin
                n_hpeak  = (opeak > hpeak) ? opeak : hpeak;
                n_hcount = span_sat;
            end else begin
                // Displace the old held run
                o_ev0_vld = hvalid && (hcount >= i_min_run);
                n_hstart  = ostart;
                n_hpeak   = opeak;
                n_hcount  = ocount;
            end
        end else if ((i_op == OP_SAMPLE) && i_meets) begin
            if (!open) begin
                n_open   = 1'b1;
                n_ostart = i_frame;
                n_opeak  = i_mag;
                n_ocount = 32'd1;
            end else begin
                if (i_mag > opeak) begin
                    n_opeak = i_mag;
                end
                if (ocount != 32'hFFFF_FFFF) begin
                    n_ocount = ocount + 32'd1;
                end
            end
        end

        // Flush the held run on finish
        if (i_op == OP_FINISH) begin
            o_ev1_vld = n_hvalid && (n_hcount >= i_min_run);
            n_hvalid  = 1'b0;
        end
    end

    always_comb begin
        o_ev0.kind      = i_kind;
        o_ev0.run_start = 40'(hstart);
        o_ev0.run_end   = 40'(hend);
        o_ev0.run_peak  = hpeak;
        o_ev0.run_count = hcount;
        o_ev1.kind      = i_kind;
        o_ev1.run_start = 40'(n_hstart);
        o_ev1.run_end   = 40'(n_hend);
        o_ev1.run_peak  = n_hpeak;
        o_ev1.run_count = n_hcount;
    end

    // Control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_open[i]   <= 1'b0;
                r_hvalid[i] <= 1'b0;
            end
        end else if (i_en) begin
            r_open[ci]   <= n_open;
            r_hvalid[ci] <= n_hvalid;
        end
    end

    // Run payload, meaningful only behind the flags
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ostart[ci] <= n_ostart;
            r_opeak[ci]  <= n_opeak;
            r_ocount[ci] <= n_ocount;
            r_hstart[ci] <= n_hstart;
            r_hend[ci]   <= n_hend;
            r_hpeak[ci]  <= n_hpeak;
            r_hcount[ci] <= n_hcount;
        end
    end

endmodule

FILE: rtl/crd_evq.sv
// Back part: queue of event bundles and the output register that sends
// one event per beat. Depends on crd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module crd_evq import crd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_evt    o_ev,
    output logic [2:0] o_ch,
    output logic    o_last
);

    localparam int QD   = EVQ_DEPTH;
    localparam int QAW  = (QD > 1) ? $clog2(QD) : 1;
    localparam int CNTW = $clog2(QD + 1);

    t_bundle          r_qb [QD];
    logic [3:0]       r_qv [QD];
    logic [QAW-1:0]   r_rd, r_wr;
    logic [CNTW-1:0]  r_cnt;
    logic             r_out_vld;
    t_evt             r_out_ev;
    logic [2:0]       r_out_ch;
    logic             r_out_last;

    logic [3:0] head_m;
    logic [3:0] rest;
    logic [1:0] sel;
    logic       emit, pop, last;

    assign o_full = (r_cnt == CNTW'(QD));
    assign head_m = r_qv[r_rd];
    assign emit   = (r_cnt != '0) && (!r_out_vld || i_ready);

    // Pick the earliest pending event of the head bundle
    always_comb begin
        priority if (head_m[0]) begin
            sel = 2'd0;
        end else if (head_m[1]) begin
            sel = 2'd1;
        end else if (head_m[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
        rest = head_m & ~(4'b0001 << sel);
        last = (rest == 4'b0000);
        pop  = emit && last;
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QAW'(QD - 1)) ? '0 : r_wr + QAW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == QAW'(QD - 1)) ? '0 : r_rd + QAW'(1);
            end
            r_cnt <= r_cnt + CNTW'(i_push) - CNTW'(pop);
        end
    end

    // Store bundles; drop each event from the mask as it leaves
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_qb[r_wr] <= i_bundle;
            r_qv[r_wr] <= i_bundle.vld;
        end
        if (emit && !last) begin
            r_qv[r_rd] <= rest;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_ev   <= r_qb[r_rd].ev[sel];
            r_out_ch   <= r_qb[r_rd].ch;
            r_out_last <= last;
        end
    end

    assign o_valid = r_out_vld;
    assign o_ev    = r_out_ev;
    assign o_ch    = r_out_ch;
    assign o_last  = r_out_last;

    `ASSERT_HOLDS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNTW'(QD))
    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full && !pop)
    `ASSERT_NEVER(a_head_empty, i_clk, i_rst_n, (r_cnt != '0) && (head_m == 4'b0000))
    `ASSERT_NEVER(a_push_empty, i_clk, i_rst_n, i_push && (i_bundle.vld == 4'b0000))

endmodule

FILE: rtl/clip_run_detector.sv
// Clipping run detector top level: configuration registers, front stage,
// hard and near tracker banks and event queue. Depends on crd_pkg.
//
// Takes one item per clock while the event queue has room. A front register
// takes the magnitude and the threshold compares and stamps the channel
// frame; the tracker banks then do a read-modify-write of that channel's
// run state, so items on the same channel may follow each other back to
// back. The events an item releases (up to two for a sample, four for a
// finish) enter a queue of two bundles and leave through an output register
// at one event per beat, after the front register, the tracker update and
// the queue in turn; input stalls only while more events are released than
// the output drains. Items on channels at or above CHANNELS are dropped.
// Write configuration only while no item is in flight.
module clip_run_detector import crd_pkg::*; #(
    parameter int CHANNELS   = CRD_CHANNELS,
    parameter int FRAME_BITS = CRD_FRAME_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input beats
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [39:0]       s_axis_tdata,  // channel_index[2:0], sample_value[34:3]
    input  logic              s_axis_tuser,  // opcode[0]
    // Event beats
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [151:0]      m_axis_tdata,  // event_channel[2:0], run_start[42:3],
                                             // run_end[82:43], run_peak[114:83],
                                             // run_count[146:115]
    output logic [1:0]        m_axis_tuser,  // event_kind[1:0]
    output logic              m_axis_tlast,  // last_event
    // Configuration writes
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [31:0]       i_cfg_wdata
);

    logic [31:0] r_hard_th, r_near_th, r_min_hard, r_min_near, r_merge_gap;
    logic        r_float_src;

    logic                  cls_valid;
    t_cls                  cls;
    logic [FRAME_BITS-1:0] cls_frame;
    logic                  adv, q_full, push;
    logic [1:0]            hard_kind;
    logic                  h_ev0_vld, h_ev1_vld, n_ev0_vld, n_ev1_vld;
    t_evt                  h_ev0, h_ev1, n_ev0, n_ev1;
    t_bundle               bundle;
    t_evt                  out_ev;
    logic [2:0]            out_ch;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hard_th   <= RST_HARD_TH;
            r_near_th   <= RST_NEAR_TH;
            r_min_hard  <= RST_MIN_RUN;
            r_min_near  <= RST_MIN_RUN;
            r_merge_gap <= '0;
            r_float_src <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_HARD_TH:   r_hard_th   <= i_cfg_wdata;
                REG_NEAR_TH:   r_near_th   <= i_cfg_wdata;
                REG_MIN_HARD:  r_min_hard  <= i_cfg_wdata;
                REG_MIN_NEAR:  r_min_near  <= i_cfg_wdata;
                REG_MERGE_GAP: r_merge_gap <= i_cfg_wdata;
                REG_FLOAT_SRC: r_float_src <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign hard_kind = r_float_src ? KIND_OVER : KIND_DIGITAL;

    crd_front #(
        .CHANNELS   (CHANNELS),
        .FRAME_BITS (FRAME_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_op      (s_axis_tuser),
        .i_ch      (s_axis_tdata[2:0]),
        .i_sample  (s_axis_tdata[34:3]),
        .i_hard_th (r_hard_th),
        .i_near_th (r_near_th),
        .i_adv     (adv),
        .o_valid   (cls_valid),
        .o_cls     (cls),
        .o_frame   (cls_frame)
    );

    // Trackers run when the queue has room for the item's events
    assign adv = cls_valid && !q_full;

    crd_trk_bank #(
        .CHANNELS   (CHANNELS),
        .FRAME_BITS (FRAME_BITS)
    ) u_hard (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (adv),
        .i_op        (cls.op),
        .i_ch        (cls.ch),
        .i_mag       (cls.mag),
        .i_meets     (cls.meets_hard),
        .i_frame     (cls_frame),
        .i_kind      (hard_kind),
        .i_merge_gap (r_merge_gap),
        .i_min_run   (r_min_hard),
        .o_ev0_vld   (h_ev0_vld),
        .o_ev0       (h_ev0),
        .o_ev1_vld   (h_ev1_vld),
        .o_ev1       (h_ev1)
    );

    crd_trk_bank #(
        .CHANNELS   (CHANNELS),
        .FRAME_BITS (FRAME_BITS)
    ) u_near (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (adv),
        .i_op        (cls.op),
        .i_ch        (cls.ch),
        .i_mag       (cls.mag),
        .i_meets     (cls.meets_near),
        .i_frame     (cls_frame),
        .i_kind      (KIND_NEAR),
        .i_merge_gap (r_merge_gap),
        .i_min_run   (r_min_near),
        .o_ev0_vld   (n_ev0_vld),
        .o_ev0       (n_ev0),
        .o_ev1_vld   (n_ev1_vld),
        .o_ev1       (n_ev1)
    );

    // Gather the item's events, hard tracker first
    always_comb begin
        bundle.ch    = cls.ch;
        bundle.vld   = {n_ev1_vld, n_ev0_vld, h_ev1_vld, h_ev0_vld};
        bundle.ev[0] = h_ev0;
        bundle.ev[1] = h_ev1;
        bundle.ev[2] = n_ev0;
        bundle.ev[3] = n_ev1;
    end

    assign push = adv && (bundle.vld != 4'b0000);

    crd_evq u_evq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .o_full   (q_full),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_ev     (out_ev),
        .o_ch     (out_ch),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, out_ev.run_count, out_ev.run_peak,
                           out_ev.run_end, out_ev.run_start, out_ch};
    assign m_axis_tuser = out_ev.kind;

endmodule

FILE: tb/sv/clip_run_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the clipping run detector: watches the input, event and
// configuration ports, predicts the run events and compares them per field.
// Depends on crd_pkg for channel count, opcodes, event kinds and register indexes.
module clip_run_checker import crd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [39:0]       i_in_data,   // channel_index[2:0], sample_value[34:3]
    input  logic              i_in_user,   // opcode[0]
    input  logic              i_ev_valid,
    input  logic              i_ev_ready,
    input  logic [151:0]      i_ev_data,   // event_channel[2:0], run_start[42:3],
                                           // run_end[82:43], run_peak[114:83],
                                           // run_count[146:115]
    input  logic [1:0]        i_ev_user,   // event_kind[1:0]
    input  logic              i_ev_last,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [31:0]       i_cfg_wdata,
    output int                o_mismatches,
    output int                o_pending
);

    localparam int NCH  = CRD_CHANNELS;
    localparam int NTRK = 2 * NCH;
    localparam logic [39:0] FRAME_TOP = '1;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  ch;
        logic [39:0] first;
        logic [39:0] stop;
        logic [31:0] peak;
        logic [31:0] len;
        logic        last;
    } clip_event_t;

    // Shadow copy of the configuration registers
    logic [31:0] hard_th;
    logic [31:0] near_th;
    logic [31:0] min_hard;
    logic [31:0] min_near;
    logic [31:0] merge_gap;
    logic        float_src;

    // Per-channel frame counters and per-tracker run state (hard = 2*ch, near = 2*ch+1)
    logic [39:0] frame_pos  [NCH];
    logic        run_active [NTRK];
    logic [39:0] open_first [NTRK];
    logic [31:0] open_peak  [NTRK];
    logic [31:0] open_len   [NTRK];
    logic        hold_valid [NTRK];
    logic [39:0] hold_first [NTRK];
    logic [39:0] hold_stop  [NTRK];
    logic [31:0] hold_peak  [NTRK];
    logic [31:0] hold_len   [NTRK];

    clip_event_t expected_events [$];
    clip_event_t item_events [$];
    int          mismatch_count;

    task automatic clear_model();
        hard_th   = RST_HARD_TH;
        near_th   = RST_NEAR_TH;
        min_hard  = RST_MIN_RUN;
        min_near  = RST_MIN_RUN;
        merge_gap = '0;
        float_src = 1'b0;
        for (int c = 0; c < NCH; c++) frame_pos[c] = '0;
        for (int t = 0; t < NTRK; t++) begin
            run_active[t] = 1'b0;
            open_first[t] = '0;
            open_peak[t]  = '0;
            open_len[t]   = '0;
            hold_valid[t] = 1'b0;
            hold_first[t] = '0;
            hold_stop[t]  = '0;
            hold_peak[t]  = '0;
            hold_len[t]   = '0;
        end
        expected_events.delete();
    endtask

    // Report the held run if it is long enough, then drop it
    task automatic emit_held(int t, logic [1:0] kind, logic [2:0] ch, logic [31:0] min_len);
        clip_event_t run;
        if (!hold_valid[t]) return;
        if (hold_len[t] >= min_len && item_events.size() < 4) begin
            run.kind  = kind;
            run.ch    = ch;
            run.first = hold_first[t];
            run.stop  = hold_stop[t];
            run.peak  = hold_peak[t];
            run.len   = hold_len[t];
            run.last  = 1'b0;
            item_events.push_back(run);
        end
        hold_valid[t] = 1'b0;
    endtask

    // Close the open run: merge it into the held run or displace the held run
    task automatic close_run(int t, logic [39:0] stop, logic [1:0] kind, logic [2:0] ch,
                             logic [31:0] min_len);
        logic [39:0] gap;
        logic [39:0] span;
        if (hold_valid[t]) begin
            gap = (open_first[t] >= hold_stop[t]) ? open_first[t] - hold_stop[t] : '0;
            if (gap <= {8'd0, merge_gap}) begin
                hold_stop[t] = stop;
                if (open_peak[t] > hold_peak[t]) hold_peak[t] = open_peak[t];
                span = (stop >= hold_first[t]) ? stop - hold_first[t] : '0;
                hold_len[t] = (span > 40'hFFFFFFFF) ? 32'hFFFFFFFF : span[31:0];
                run_active[t] = 1'b0;
                open_len[t]   = '0;
                return;
            end
            emit_held(t, kind, ch, min_len);
        end
        hold_first[t] = open_first[t];
        hold_stop[t]  = stop;
        hold_peak[t]  = open_peak[t];
        hold_len[t]   = open_len[t];
        hold_valid[t] = 1'b1;
        run_active[t] = 1'b0;
        open_len[t]   = '0;
    endtask

    // Grow the open run on a meeting sample, close it on the first miss
    task automatic feed_tracker(int t, logic [39:0] frame, logic [31:0] mag, logic meets,
                                logic [1:0] kind, logic [2:0] ch, logic [31:0] min_len);
        if (meets) begin
            if (!run_active[t]) begin
                run_active[t] = 1'b1;
                open_first[t] = frame;
                open_peak[t]  = mag;
                open_len[t]   = 32'd1;
            end else begin
                if (mag > open_peak[t]) open_peak[t] = mag;
                if (open_len[t] != 32'hFFFFFFFF) open_len[t] = open_len[t] + 32'd1;
            end
        end else if (run_active[t]) begin
            close_run(t, frame, kind, ch, min_len);
        end
    endtask

    // Work out the events one accepted item releases and queue them
    task automatic predict_events(logic op, logic [2:0] ch, logic [31:0] raw);
        logic [31:0] mag;
        logic [39:0] frame;
        logic [1:0]  hk;
        clip_event_t run;
        int          th;
        int          tn;
        item_events.delete();
        if (int'(ch) >= NCH) return;
        hk = float_src ? KIND_OVER : KIND_DIGITAL;
        th = 2 * int'(ch);
        tn = th + 1;
        frame = frame_pos[ch];
        if (op == OP_SAMPLE) begin
            mag = raw[31] ? -raw : raw;
            feed_tracker(th, frame, mag, mag >= hard_th, hk, ch, min_hard);
            feed_tracker(tn, frame, mag, mag >= near_th, KIND_NEAR, ch, min_near);
            if (frame != FRAME_TOP) frame_pos[ch] = frame + 40'd1;
        end else begin
            if (run_active[th]) close_run(th, frame, hk, ch, min_hard);
            emit_held(th, hk, ch, min_hard);
            if (run_active[tn]) close_run(tn, frame, KIND_NEAR, ch, min_near);
            emit_held(tn, KIND_NEAR, ch, min_near);
        end
        for (int i = 0; i < item_events.size(); i++) begin
            run = item_events[i];
            run.last = (i == item_events.size() - 1);
            expected_events.push_back(run);
        end
    endtask

    // Compare one event beat with the oldest prediction
    task automatic check_event();
        clip_event_t got;
        clip_event_t want;
        got.kind  = i_ev_user;
        got.ch    = i_ev_data[2:0];
        got.first = i_ev_data[42:3];
        got.stop  = i_ev_data[82:43];
        got.peak  = i_ev_data[114:83];
        got.len   = i_ev_data[146:115];
        got.last  = i_ev_last;
        if (expected_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("%0t: unexpected event kind=%0d ch=%0d start=%0d end=%0d",
                         $time, got.kind, got.ch, got.first, got.stop);
        end else begin
            want = expected_events.pop_front();
            if (got.kind !== want.kind || got.ch !== want.ch || got.first !== want.first ||
                got.stop !== want.stop || got.peak !== want.peak || got.len !== want.len ||
                got.last !== want.last) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("%0t: event mismatch exp kind=%0d ch=%0d start=%0d end=%0d",
                             $time, want.kind, want.ch, want.first, want.stop);
                    $display("    exp peak=%0d count=%0d last=%0d | got kind=%0d ch=%0d",
                             want.peak, want.len, want.last, got.kind, got.ch);
                    $display("    got start=%0d end=%0d peak=%0d count=%0d last=%0d",
                             got.first, got.stop, got.peak, got.len, got.last);
                end
            end
        end
    endtask

    initial begin
        mismatch_count = 0;
        clear_model();
    end

    // Sample all ports on the rising edge; outputs go out by nonblocking assignment
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_ev_valid && i_ev_ready) check_event();
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_HARD_TH:   hard_th   = i_cfg_wdata;
                    REG_NEAR_TH:   near_th   = i_cfg_wdata;
                    REG_MIN_HARD:  min_hard  = i_cfg_wdata;
                    REG_MIN_NEAR:  min_near  = i_cfg_wdata;
                    REG_MERGE_GAP: merge_gap = i_cfg_wdata;
                    REG_FLOAT_SRC: float_src = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_events(i_in_user, i_in_data[2:0],
                                                         i_in_data[34:3]);
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_events.size();
    end

endmodule

FILE: tb/sv/clip_run_detector_tb.sv
`timescale 1ns / 100ps
// Top of the clipping run detector testbench: clock, reset, configuration
// phases and sample stimulus; checking is done by clip_run_checker.
// Depends on crd_pkg, clip_run_detector and clip_run_checker.
module clip_run_detector_tb;
    import crd_pkg::*;

    localparam int QUIET_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 8;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [39:0]       s_axis_tdata  = '0;
    logic              s_axis_tuser  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [151:0]      m_axis_tdata;
    logic [1:0]        m_axis_tuser;
    logic              m_axis_tlast;
    logic              i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr    = '0;
    logic [31:0]       i_cfg_wdata   = '0;

    logic        idle_en  = 1'b1;
    int          mismatches;
    int          pending;
    int          quiet_cycles = 0;
    logic [31:0] cur_hard = RST_HARD_TH;
    logic [31:0] cur_near = RST_NEAR_TH;
    logic [2:0]  burst_ch = '0;

    clip_run_detector u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    clip_run_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_ev_valid   (m_axis_tvalid),
        .i_ev_ready   (m_axis_tready),
        .i_ev_data    (m_axis_tdata),
        .i_ev_user    (m_axis_tuser),
        .i_ev_last    (m_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Stall the event side at random while idling is enabled
    always @(posedge i_clk) begin
        m_axis_tready <= !idle_en || ($urandom_range(99) >= 17);
    end

    // End the run when no beat moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Present one input beat, maybe with valid dropped first, and hold it until taken
    task automatic send_item(logic op, logic [2:0] ch, logic [31:0] sample);
        if (idle_en && $urandom_range(99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'd0, sample, ch};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Wait for every predicted event, then let in-flight items drain
    task automatic wait_idle();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] addr, logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_config(logic [31:0] hard, logic [31:0] near, logic [31:0] min_h,
                                logic [31:0] min_n, logic [31:0] gap, logic fsrc);
        write_reg(REG_HARD_TH, hard);
        write_reg(REG_NEAR_TH, near);
        write_reg(REG_MIN_HARD, min_h);
        write_reg(REG_MIN_NEAR, min_n);
        write_reg(REG_MERGE_GAP, gap);
        write_reg(REG_FLOAT_SRC, {31'd0, fsrc});
        i_cfg_we <= 1'b0;
        cur_hard = hard;
        cur_near = near;
    endtask

    function automatic logic [31:0] with_sign(logic [31:0] mag);
        return ($urandom_range(1) != 0) ? -mag : mag;
    endfunction

    // Pick a sample loud, between the thresholds, or quiet
    function automatic logic [31:0] pick_level();
        logic [31:0] lo;
        logic [31:0] hi;
        int          roll;
        lo = (cur_hard < cur_near) ? cur_hard : cur_near;
        hi = (cur_hard < cur_near) ? cur_near : cur_hard;
        roll = $urandom_range(99);
        if (roll < 45) return with_sign($urandom_range(32'h80000000, hi));
        if (roll < 60) return with_sign($urandom_range(hi, lo));
        if (lo == 0) return 32'd0;
        return with_sign($urandom_range(lo - 32'd1, 0));
    endfunction

    // Bursts of samples on one channel with random finishes and some noise,
    // then finish every channel to flush held runs
    task automatic run_phase(int n_items, int pause_at);
        int roll;
        for (int i = 0; i < n_items; i++) begin
            if (i == pause_at) begin
                s_axis_tvalid <= 1'b0;
                wait_idle();
            end
            if ($urandom_range(99) < 20) burst_ch = 3'($urandom_range(7));
            roll = $urandom_range(99);
            if (roll < 7)
                send_item(OP_FINISH, burst_ch, $urandom);
            else if (roll < 12)
                send_item(1'($urandom_range(1)), 3'($urandom_range(7)), $urandom);
            else
                send_item(OP_SAMPLE, burst_ch, pick_level());
        end
        for (int c = 0; c < CRD_CHANNELS; c++) send_item(OP_FINISH, c[2:0], $urandom);
        s_axis_tvalid <= 1'b0;
        wait_idle();
    endtask

    initial begin
        logic [31:0] hard_pick;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset settings: three-sample hard and near runs closed by a quiet sample
        send_item(OP_SAMPLE, 3'd0, 32'd8388607);
        send_item(OP_SAMPLE, 3'd0, 32'hFF800000);
        send_item(OP_SAMPLE, 3'd0, 32'h7FFFFFFF);
        send_item(OP_SAMPLE, 3'd0, 32'd0);
        // Near-only run displaces the held near run
        send_item(OP_SAMPLE, 3'd0, 32'd7500000);
        send_item(OP_SAMPLE, 3'd0, 32'd7500000);
        send_item(OP_SAMPLE, 3'd0, 32'd7500000);
        send_item(OP_SAMPLE, 3'd0, 32'hFFFFFFFF);
        send_item(OP_FINISH, 3'd0, 32'd0);
        // Most negative samples, then a finish with held and open runs on both trackers
        send_item(OP_SAMPLE, 3'd7, 32'h80000000);
        send_item(OP_SAMPLE, 3'd7, 32'h80000000);
        send_item(OP_SAMPLE, 3'd7, 32'd8388607);
        send_item(OP_SAMPLE, 3'd7, 32'd1);
        send_item(OP_SAMPLE, 3'd7, 32'd8388607);
        send_item(OP_SAMPLE, 3'd7, 32'd8388607);
        send_item(OP_SAMPLE, 3'd7, 32'd8388607);
        send_item(OP_FINISH, 3'd7, 32'd0);
        // Finish on an empty channel, threshold edges, short run below the minimum
        send_item(OP_FINISH, 3'd3, 32'd0);
        send_item(OP_SAMPLE, 3'd3, 32'd7476678);
        send_item(OP_SAMPLE, 3'd3, 32'd7476679);
        send_item(OP_SAMPLE, 3'd3, 32'd7476679);
        send_item(OP_FINISH, 3'd3, 32'd0);
        s_axis_tvalid <= 1'b0;
        wait_idle();

        // Long stretch without idling on either side
        idle_en = 1'b0;
        apply_config(32'h00800000, 32'd6000000, 32'd2, 32'd4, 32'd2, 1'b1);
        run_phase(80, -1);

        // Zero thresholds: every sample meets; widest merge gap
        idle_en = 1'b1;
        apply_config(32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFFFFFF, 1'b0);
        run_phase(60, -1);

        // Top thresholds: only the most negative sample meets; drain midway
        apply_config(32'h80000000, 32'h80000000, 32'd1, 32'd1, 32'd1, 1'b1);
        run_phase(60, 30);

        // Largest minimums: runs are tracked but never reported
        apply_config($urandom_range(32'h00800000, 32'h00100000),
                     $urandom_range(32'h00800000, 32'h00100000),
                     32'hFFFFFFFF, 32'hFFFFFFFF, $urandom_range(3), 1'b0);
        run_phase(50, -1);

        // Random settings with near below hard
        repeat (2) begin
            hard_pick = $urandom_range(32'h80000000, 32'h00100000);
            apply_config(hard_pick, $urandom_range(hard_pick, 32'h00080000),
                         $urandom_range(5), $urandom_range(5), $urandom_range(4),
                         1'($urandom_range(1)));
            run_phase(80, -1);
        end

        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
